// ----- rtl/core/access_lockout_sequencer_core_assert.svh -----
`ifndef ACCESS_LOCKOUT_SEQUENCER_CORE_ASSERT_SVH
`define ACCESS_LOCKOUT_SEQUENCER_CORE_ASSERT_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ALS_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Same check on the block's clk and rst_n.
`define ALS_ASSERT(lbl, prop, msg) \
  `ALS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ----- rtl/core/als_pkg.sv -----
package als_pkg;

  localparam int ID_BITS     = 32;
  localparam int TIMER_W     = 16;
  localparam int FAIL_W      = 4;
  localparam int USED_W      = 7;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  // item kinds
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_CHECK    = 3'd1;
  localparam logic [2:0] KIND_ENROLL   = 3'd2;
  localparam logic [2:0] KIND_CLEAR    = 3'd3;
  localparam logic [2:0] KIND_RST_AUTH = 3'd4;

  // buzzer events
  localparam logic [2:0] TONE_NONE    = 3'd0;
  localparam logic [2:0] TONE_SCAN    = 3'd1;
  localparam logic [2:0] TONE_PROCESS = 3'd2;
  localparam logic [2:0] TONE_SUCCESS = 3'd3;
  localparam logic [2:0] TONE_FAIL    = 3'd4;
  localparam logic [2:0] TONE_CHIRP   = 3'd5;
  localparam logic [2:0] TONE_SILENCE = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIRP   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 4'd7;

  // configuration reset values
  localparam logic [TIMER_W-1:0] RST_WAIT    = 16'd1000;
  localparam logic [TIMER_W-1:0] RST_SCAN    = 16'd700;
  localparam logic [TIMER_W-1:0] RST_PROCESS = 16'd900;
  localparam logic [TIMER_W-1:0] RST_VERIFY  = 16'd600;
  localparam logic [TIMER_W-1:0] RST_HOLD    = 16'd3000;
  localparam logic [TIMER_W-1:0] RST_ALARM   = 16'd30000;
  localparam logic [TIMER_W-1:0] RST_CHIRP   = 16'd500;
  localparam logic [FAIL_W-1:0]  RST_LIMIT   = 4'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_SCAN    = 3'd2,
    PH_PROCESS = 3'd3,
    PH_VERIFY  = 3'd4,
    PH_GRANT   = 3'd5,
    PH_DENY    = 3'd6,
    PH_ALARM   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ID_BITS-1:0] ident;
  } in_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic [FAIL_W-1:0] fail_count;
    logic              last_granted;
    logic              last_happened;
    logic [2:0]        tone;
    logic [USED_W-1:0] entries_used;
    logic              accepted;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic search_init;
    logic search_run;
    logic apply_live;
    logic apply_verify;
  } als_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_search;
    logic search_done;
  } als_sts_t;

endpackage

// ----- rtl/core/als_ram.sv -----
module als_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/als_datapath.sv -----
module als_datapath import als_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_t                   in_data,
  input  als_cmd_t              cmd,
  output als_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output out_t                  out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // configuration
  logic [TIMER_W-1:0] wait_r, scan_r, process_r, verify_r;
  logic [TIMER_W-1:0] hold_r, alarm_r, chirp_r;
  logic [FAIL_W-1:0]  limit_r;

  // sequencer state
  phase_t             phase_r, phase_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W-1:0] chirp_cnt_r, chirp_cnt_nxt;
  logic [FAIL_W-1:0]  fail_r, fail_nxt;
  logic               granted_r, granted_nxt;
  logic               happened_r, happened_nxt;
  logic [ID_BITS-1:0] pending_r, pending_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // table search
  logic [CNT_W-1:0]   srch_idx_r;
  logic               cmp_valid_r;
  logic               found_r;
  logic               rd_en;
  logic [ID_BITS-1:0] ram_q;

  logic               out_valid_r;
  out_t               out_r;

  logic               apply;
  logic [2:0]         kind_eff;
  logic [2:0]         tone;
  logic               acc;
  logic               ram_we;
  logic [TIMER_W-1:0] tinc, cinc;
  logic [FAIL_W-1:0]  fail_inc;

  assign tinc     = sat_inc(timer_r);
  assign cinc     = sat_inc(chirp_cnt_r);
  assign fail_inc = (fail_r == FAIL_MAX) ? fail_r : fail_r + 1'b1;
  assign apply    = cmd.apply_live | cmd.apply_verify;
  // a search always ends a verify-phase tick
  assign kind_eff = cmd.apply_verify ? KIND_TICK : in_data.kind;

  assign sts.need_search = (in_data.kind == KIND_TICK) && (phase_r == PH_VERIFY) &&
                           (tinc >= verify_r);
  assign sts.search_done = !cmp_valid_r && (srch_idx_r >= count_r);

  assign rd_en = cmd.search_run && (srch_idx_r < count_r);

  als_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_data.ident),
    .re    (rd_en),
    .raddr (srch_idx_r[IDX_W-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    chirp_cnt_nxt = chirp_cnt_r;
    fail_nxt      = fail_r;
    granted_nxt   = granted_r;
    happened_nxt  = happened_r;
    pending_nxt   = pending_r;
    count_nxt     = count_r;
    tone          = TONE_NONE;
    acc           = 1'b0;
    ram_we        = 1'b0;
    if (apply) begin
      unique case (kind_eff)
        KIND_TICK: begin
          timer_nxt = tinc;
          unique case (phase_r)
            PH_IDLE: begin
              timer_nxt = '0;
            end
            PH_WAIT: begin
              if (tinc >= wait_r) begin
                phase_nxt = PH_SCAN;
                timer_nxt = '0;
                tone      = TONE_SCAN;
              end
            end
            PH_SCAN: begin
              if (tinc >= scan_r) begin
                phase_nxt = PH_PROCESS;
                timer_nxt = '0;
                tone      = TONE_PROCESS;
              end
            end
            PH_PROCESS: begin
              if (tinc >= process_r) begin
                phase_nxt = PH_VERIFY;
                timer_nxt = '0;
              end
            end
            PH_VERIFY: begin
              if (tinc >= verify_r) begin
                happened_nxt = 1'b1;
                granted_nxt  = found_r;
                timer_nxt    = '0;
                if (found_r) begin
                  phase_nxt = PH_GRANT;
                  fail_nxt  = '0;
                  tone      = TONE_SUCCESS;
                end else begin
                  phase_nxt = PH_DENY;
                  fail_nxt  = fail_inc;
                  tone      = TONE_FAIL;
                  if (fail_inc >= limit_r) begin
                    phase_nxt     = PH_ALARM;
                    chirp_cnt_nxt = chirp_r;
                  end
                end
              end
            end
            PH_GRANT, PH_DENY: begin
              if (tinc >= hold_r) begin
                phase_nxt = PH_IDLE;
                timer_nxt = '0;
              end
            end
            PH_ALARM: begin
              chirp_cnt_nxt = cinc;
              if (cinc >= chirp_r) begin
                chirp_cnt_nxt = '0;
                tone          = TONE_CHIRP;
              end
              // alarm end overrides a chirp on the same tick
              if (tinc >= alarm_r) begin
                phase_nxt = PH_IDLE;
                timer_nxt = '0;
                fail_nxt  = '0;
                tone      = TONE_SILENCE;
              end
            end
            default: begin
              timer_nxt = '0;
            end
          endcase
        end
        KIND_CHECK: begin
          if (phase_r == PH_IDLE || phase_r == PH_GRANT || phase_r == PH_DENY) begin
            pending_nxt  = in_data.ident;
            phase_nxt    = PH_WAIT;
            timer_nxt    = '0;
            happened_nxt = 1'b0;
            acc          = 1'b1;
          end
        end
        KIND_ENROLL: begin
          if (count_r < DEPTH_CNT) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            acc       = 1'b1;
          end
        end
        KIND_CLEAR: begin
          count_nxt = '0;
        end
        KIND_RST_AUTH: begin
          phase_nxt     = PH_IDLE;
          pending_nxt   = '0;
          happened_nxt  = 1'b0;
          timer_nxt     = '0;
          chirp_cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r      <= RST_WAIT;
      scan_r      <= RST_SCAN;
      process_r   <= RST_PROCESS;
      verify_r    <= RST_VERIFY;
      hold_r      <= RST_HOLD;
      alarm_r     <= RST_ALARM;
      chirp_r     <= RST_CHIRP;
      limit_r     <= RST_LIMIT;
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      chirp_cnt_r <= '0;
      fail_r      <= '0;
      granted_r   <= 1'b0;
      happened_r  <= 1'b0;
      pending_r   <= '0;
      count_r     <= '0;
      srch_idx_r  <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WAIT:    wait_r    <= cfg_data;
          CFG_SCAN:    scan_r    <= cfg_data;
          CFG_PROCESS: process_r <= cfg_data;
          CFG_VERIFY:  verify_r  <= cfg_data;
          CFG_HOLD:    hold_r    <= cfg_data;
          CFG_ALARM:   alarm_r   <= cfg_data;
          CFG_CHIRP:   chirp_r   <= cfg_data;
          CFG_LIMIT:   limit_r   <= cfg_data[FAIL_W-1:0];
          default: begin
          end
        endcase
      end
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      chirp_cnt_r <= chirp_cnt_nxt;
      fail_r      <= fail_nxt;
      granted_r   <= granted_nxt;
      happened_r  <= happened_nxt;
      pending_r   <= pending_nxt;
      count_r     <= count_nxt;
      out_valid_r <= apply;
      if (cmd.search_init) begin
        srch_idx_r  <= '0;
        cmp_valid_r <= 1'b0;
        found_r     <= 1'b0;
      end else if (cmd.search_run) begin
        // read issued this cycle, compared the next
        if (rd_en) begin
          srch_idx_r <= srch_idx_r + 1'b1;
        end
        cmp_valid_r <= rd_en;
        if (cmp_valid_r && (ram_q == pending_r)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_r.phase         <= phase_nxt;
      out_r.fail_count    <= fail_nxt;
      out_r.last_granted  <= granted_nxt;
      out_r.last_happened <= happened_nxt;
      out_r.tone          <= tone;
      out_r.entries_used  <= USED_W'(count_nxt);
      out_r.accepted      <= acc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/als_ctrl.sv -----
module als_ctrl import als_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  als_sts_t sts,
  output als_cmd_t cmd,
  output logic     busy
);

  typedef enum logic {
    C_IDLE   = 1'b0,
    C_SEARCH = 1'b1
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          if (sts.need_search) begin
            cmd.search_init = 1'b1;
            state_nxt       = C_SEARCH;
          end else begin
            cmd.apply_live = 1'b1;
          end
        end
      end
      C_SEARCH: begin
        cmd.search_run = 1'b1;
        if (sts.search_done) begin
          cmd.apply_verify = 1'b1;
          state_nxt        = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != C_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- rtl/core/access_lockout_sequencer_core.sv -----
// Access lockout sequencer. Each transfer on start/in_data (taken when busy is low) gives
// exactly one result on out_data, strobed by out_valid for one cycle; the receiver cannot
// stall, so results must be captured when the strobe is seen. For most items the result
// appears on the cycle after the transfer and busy stays low. The tick that ends the
// verifying phase searches the ID table through its single registered read port, one
// entry per cycle, with busy high during the search, and the result shows in the cycle
// busy falls. Configuration writes on cfg_* are always ready and should be made while the
// block is idle. There is no clearing pass after reset.
module access_lockout_sequencer_core import als_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  als_cmd_t cmd;
  als_sts_t sts;
  logic     ctrl_busy;
  logic     start_ok;

  assign start_ok  = start & ~ctrl_busy;
  assign cfg_ready = 1'b1;
  assign busy      = ctrl_busy;

  als_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  als_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/als_checker.sv -----
`include "access_lockout_sequencer_core_assert.svh"

module als_checker import als_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  // a result shows only after a transfer or at the end of a table search
  `ALS_ASSERT(a_out_has_cause, out_valid |-> ($past(start && !busy) || $past(busy)), "result without cause")

  // busy rises only on a transfer
  `ALS_ASSERT(a_busy_from_xfer, $rose(busy) |-> $past(start), "busy without transfer")

  // a search ends with its result
  `ALS_ASSERT(a_search_result, $fell(busy) |-> out_valid, "search ended without result")

  // a taken check or enroll never sounds the buzzer
  `ALS_ASSERT(a_acc_no_tone, (out_valid && out_data.accepted) |-> (out_data.tone == TONE_NONE), "tone on accepted item")

  // alarm end leaves the block idle with failures cleared
  `ALS_ASSERT(a_silence_idle, (out_valid && out_data.tone == TONE_SILENCE) |-> (out_data.phase == PH_IDLE && out_data.fail_count == '0), "silence outside alarm end")

endmodule

bind access_lockout_sequencer_core als_checker u_als_checker (.*);
